>>> rtl/rscr_pkg.sv
// shared types and constants for the remote switch command retry controller
// no dependencies; imported by every other file of the block
`default_nettype none

package rscr_pkg;

  localparam int TIMER_WIDTH_DEF = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd3;
  localparam logic [7:0] TIMEOUT_RST = 8'd10;
  localparam logic [7:0] DELAY_RST = 8'd5;

  typedef enum logic [2:0] {
    REG_USER_ENABLE     = 3'd0,
    REG_RETRY_LIMIT     = 3'd1,
    REG_TIMEOUT_SECONDS = 3'd2,
    REG_DELAY_SECONDS   = 3'd3,
    REG_FEEDBACK_USED   = 3'd4,
    REG_FEEDBACK_INVERT = 3'd5,
    REG_PERMIT_USED     = 3'd6,
    REG_PERMIT_INVERT   = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    MODE_IDLE      = 5'b00001,
    MODE_TRY_ON    = 5'b00010,
    MODE_TRY_OFF   = 5'b00100,
    MODE_DELAY_ON  = 5'b01000,
    MODE_DELAY_OFF = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    DRIVE_HOLD = 2'd0,
    DRIVE_ON   = 2'd1,
    DRIVE_OFF  = 2'd2
  } drive_t;

  typedef enum logic [2:0] {
    ST_DONE_OFF   = 3'd0,
    ST_DONE_ON    = 3'd1,
    ST_USER_BLOCK = 3'd2,
    ST_HW_BLOCK   = 3'd3,
    ST_EXHAUSTED  = 3'd4,
    ST_BUSY       = 3'd5
  } status_t;

  typedef struct packed {
    logic       user_enable;
    logic [7:0] retry_limit;
    logic [7:0] timeout_seconds;
    logic [7:0] delay_seconds;
    logic       feedback_used;
    logic       feedback_invert;
    logic       permit_used;
    logic       permit_invert;
  } cfg_t;

  typedef struct packed {
    logic command_value;
    logic second_tick;
    logic feedback_raw;
    logic permit_raw;
  } item_t;

  typedef struct packed {
    drive_t  drive;
    logic    status_valid;
    status_t status_code;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/rscr_if.sv
// valid/ready channel interfaces for command items and results
// depends on rscr_pkg for the drive and status types
`default_nettype none

interface rscr_item_if;
  logic valid;
  logic ready;
  logic command_value;
  logic second_tick;
  logic feedback_raw;
  logic permit_raw;

  modport source (output valid, command_value, second_tick, feedback_raw, permit_raw,
                  input ready);
  modport sink (input valid, command_value, second_tick, feedback_raw, permit_raw,
                output ready);
endinterface

interface rscr_result_if;
  logic              valid;
  logic              ready;
  rscr_pkg::drive_t  drive;
  logic              status_valid;
  rscr_pkg::status_t status_code;

  modport source (output valid, drive, status_valid, status_code, input ready);
  modport sink (input valid, drive, status_valid, status_code, output ready);
endinterface

`default_nettype wire

>>> rtl/rscr_cfg.sv
// apb register file holding the controller configuration
// depends on rscr_pkg
`default_nettype none

module rscr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rscr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rscr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rscr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output rscr_pkg::cfg_t                       cfg
);
  import rscr_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.user_enable     <= 1'b0;
      cfg.retry_limit     <= RETRY_LIMIT_RST;
      cfg.timeout_seconds <= TIMEOUT_RST;
      cfg.delay_seconds   <= DELAY_RST;
      cfg.feedback_used   <= 1'b0;
      cfg.feedback_invert <= 1'b0;
      cfg.permit_used     <= 1'b0;
      cfg.permit_invert   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_USER_ENABLE:     cfg.user_enable     <= pwdata[0];
        REG_RETRY_LIMIT:     cfg.retry_limit     <= pwdata[7:0];
        REG_TIMEOUT_SECONDS: cfg.timeout_seconds <= pwdata[7:0];
        REG_DELAY_SECONDS:   cfg.delay_seconds   <= pwdata[7:0];
        REG_FEEDBACK_USED:   cfg.feedback_used   <= pwdata[0];
        REG_FEEDBACK_INVERT: cfg.feedback_invert <= pwdata[0];
        REG_PERMIT_USED:     cfg.permit_used     <= pwdata[0];
        REG_PERMIT_INVERT:   cfg.permit_invert   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_USER_ENABLE:     prdata[0]   = cfg.user_enable;
      REG_RETRY_LIMIT:     prdata[7:0] = cfg.retry_limit;
      REG_TIMEOUT_SECONDS: prdata[7:0] = cfg.timeout_seconds;
      REG_DELAY_SECONDS:   prdata[7:0] = cfg.delay_seconds;
      REG_FEEDBACK_USED:   prdata[0]   = cfg.feedback_used;
      REG_FEEDBACK_INVERT: prdata[0]   = cfg.feedback_invert;
      REG_PERMIT_USED:     prdata[0]   = cfg.permit_used;
      REG_PERMIT_INVERT:   prdata[0]   = cfg.permit_invert;
      default:             prdata      = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/rscr_ctrl.sv
// command state machine with attempt counter and the two second timers
// depends on rscr_pkg; advances one step per transfer handed to it
`default_nettype none

module rscr_ctrl #(
  parameter int TIMER_WIDTH = rscr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  rscr_pkg::cfg_t  cfg,
  input  wire logic       step,
  input  rscr_pkg::item_t item,
  output rscr_pkg::result_t res
);
  import rscr_pkg::*;

  localparam int CmpW = (TIMER_WIDTH > 8) ? TIMER_WIDTH : 8;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  mode_t                  mode, mode_next;
  logic                   last_value, last_value_next;
  logic [7:0]             attempt_count, attempt_count_next;
  logic [TIMER_WIDTH-1:0] command_elapsed, command_elapsed_next;
  logic [TIMER_WIDTH-1:0] delay_elapsed, delay_elapsed_next;

  logic [TIMER_WIDTH-1:0] cmd_t, dly_t;
  logic [7:0]             attempt_inc;
  logic                   permit, feedback, is_on, timed_out, delay_done;

  always_comb begin
    cmd_t = (item.second_tick && command_elapsed != TimerMax) ?
            command_elapsed + 1'b1 : command_elapsed;
    dly_t = (item.second_tick && delay_elapsed != TimerMax) ?
            delay_elapsed + 1'b1 : delay_elapsed;
    timed_out   = CmpW'(cmd_t) >= CmpW'(cfg.timeout_seconds);
    delay_done  = CmpW'(dly_t) >= CmpW'(cfg.delay_seconds);
    attempt_inc = (attempt_count != 8'hFF) ? attempt_count + 8'd1 : attempt_count;
    permit   = cfg.permit_used ? (item.permit_raw ^ cfg.permit_invert) : 1'b1;
    feedback = cfg.feedback_used ? (item.feedback_raw ^ cfg.feedback_invert) : last_value;
    is_on    = (mode == MODE_TRY_ON) || (mode == MODE_DELAY_ON);

    mode_next            = mode;
    last_value_next      = last_value;
    attempt_count_next   = attempt_count;
    command_elapsed_next = cmd_t;
    delay_elapsed_next   = dly_t;
    res.drive            = DRIVE_HOLD;
    res.status_valid     = 1'b0;
    res.status_code      = ST_DONE_OFF;

    unique case (mode)
      MODE_IDLE: begin
        if (last_value != item.command_value) begin
          res.status_valid = 1'b1;
          if (!permit) begin
            res.status_code = ST_HW_BLOCK;
          end else if (!cfg.user_enable) begin
            res.status_code = ST_USER_BLOCK;
          end else begin
            res.status_code      = ST_BUSY;
            command_elapsed_next = '0;
            last_value_next      = item.command_value;
            mode_next = item.command_value ? MODE_TRY_ON : MODE_TRY_OFF;
            res.drive = item.command_value ? DRIVE_ON : DRIVE_OFF;
          end
        end
      end
      MODE_TRY_ON, MODE_TRY_OFF: begin
        if (feedback == is_on) begin
          last_value_next    = is_on;
          res.status_valid   = 1'b1;
          res.status_code    = is_on ? ST_DONE_ON : ST_DONE_OFF;
          attempt_count_next = '0;
          mode_next          = MODE_IDLE;
        end else if (timed_out) begin
          if (attempt_inc >= cfg.retry_limit) begin
            last_value_next    = item.command_value;
            attempt_count_next = '0;
            res.status_valid   = 1'b1;
            res.status_code    = ST_EXHAUSTED;
            mode_next          = MODE_IDLE;
          end else begin
            attempt_count_next = attempt_inc;
            delay_elapsed_next = '0;
            mode_next          = is_on ? MODE_DELAY_ON : MODE_DELAY_OFF;
          end
        end
      end
      MODE_DELAY_ON, MODE_DELAY_OFF: begin
        if (delay_done) begin
          mode_next = is_on ? MODE_TRY_ON : MODE_TRY_OFF;
          res.drive = is_on ? DRIVE_ON : DRIVE_OFF;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      last_value      <= 1'b0;
      attempt_count   <= '0;
      command_elapsed <= '0;
      delay_elapsed   <= '0;
    end else if (step) begin
      mode            <= mode_next;
      last_value      <= last_value_next;
      attempt_count   <= attempt_count_next;
      command_elapsed <= command_elapsed_next;
      delay_elapsed   <= delay_elapsed_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/remote_switch_command_retry_fsm_core.sv
// Remote on/off command controller. Each transfer on item carries the
// requested value, a one-second tick and the raw feedback and permit lines;
// each one gives exactly one transfer on result with the drive request and an
// optional status code. The block takes one item per clock: an item is held in
// the input register, the state machine step runs between that register and the
// result register, which offers the item's result, and back-pressure on result
// only stalls the block once both registers are full. Configuration must be
// written over the apb port only while no item is in flight; the block does not
// enforce this. The timers are TIMER_WIDTH bits and saturate.
// depends on rscr_pkg, rscr_if, rscr_cfg and rscr_ctrl
`default_nettype none

module remote_switch_command_retry_fsm_core #(
  parameter int TIMER_WIDTH = rscr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rscr_item_if.sink                            item,
  rscr_result_if.source                        result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rscr_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rscr_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rscr_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import rscr_pkg::*;

  cfg_t    cfg;
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_adv;
  result_t step_res;
  result_t out_res;
  logic    out_valid;

  rscr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv     = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_item.command_value <= item.command_value;
      s1_item.second_tick   <= item.second_tick;
      s1_item.feedback_raw  <= item.feedback_raw;
      s1_item.permit_raw    <= item.permit_raw;
    end
  end

  rscr_ctrl #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (s1_adv),
    .item (s1_item),
    .res  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= step_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.drive        = out_res.drive;
  assign result.status_valid = out_res.status_valid;
  assign result.status_code  = out_res.status_code;

endmodule

`default_nettype wire

>>> rtl/rscr_checker.sv
// port-level checks on the result channel of the controller
// depends on rscr_pkg; bound to remote_switch_command_retry_fsm_core
`default_nettype none

module rscr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              valid,
  input wire logic              ready,
  input rscr_pkg::drive_t       drive,
  input wire logic              status_valid,
  input rscr_pkg::status_t      status_code
);
  import rscr_pkg::*;

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> (drive == DRIVE_HOLD || drive == DRIVE_ON || drive == DRIVE_OFF))
    else $error("drive carries an unused code");

  a_quiet_status: assert property (@(posedge clk) disable iff (rst)
    (valid && !status_valid) |-> status_code == ST_DONE_OFF)
    else $error("status code set without status valid");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    (valid && status_valid) |-> (status_code == ST_DONE_OFF || status_code == ST_DONE_ON ||
      status_code == ST_USER_BLOCK || status_code == ST_HW_BLOCK ||
      status_code == ST_EXHAUSTED || status_code == ST_BUSY))
    else $error("status code out of range");

  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && status_valid && drive != DRIVE_HOLD) |-> status_code == ST_BUSY)
    else $error("command issued with a status other than busy");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(drive) && $stable(status_valid) &&
      $stable(status_code)))
    else $error("stalled result changed");

endmodule

bind remote_switch_command_retry_fsm_core rscr_checker u_rscr_checker (
  .clk          (clk),
  .rst          (rst),
  .valid        (result.valid),
  .ready        (result.ready),
  .drive        (result.drive),
  .status_valid (result.status_valid),
  .status_code  (result.status_code)
);

`default_nettype wire
